// File: src/pos3d_pkg.sv
// shared types and constants of the 3-d point-on-segment test
`timescale 1ns / 1ps

package pos3d_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 296;
    localparam int M_TDATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int NEAR_W     = 32;
    localparam int COS_W      = 17;

    localparam logic [NEAR_W-1:0] NEAR_RESET = 32'd1;
    localparam logic [COS_W-1:0]  COS_RESET  = 17'd65517;

    localparam logic [7:0] DIMS_ACCEPTED = 8'd3;

    // pipeline depth, output register included
    localparam int NUM_STAGES = 9;

    // operand width of the registered multiplier
    localparam int MUL_W = 34;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_DIST_SQ = 8'd0,
        REG_COS_SQ_LIMIT = 8'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OC_BAD_DIM       = 3'd0,
        OC_ENDS_COINCIDE = 3'd1,
        OC_NEAR_END      = 3'd2,
        OC_ANGLE_WIDE    = 3'd3,
        OC_BEYOND        = 3'd4,
        OC_BETWEEN       = 3'd5
    } outcome_t;

    // verdict carried down the pipe once the cheap rules are known
    typedef struct packed {
        logic     early;    // decided before the angle compare
        outcome_t code;
        logic     between;
        logic     beyond;   // test vector longer than segment
    } verdict_t;

endpackage

// File: src/pos3d_mul.sv
// registered signed multiplier with a load enable
`timescale 1ns / 1ps

module pos3d_mul
    import pos3d_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [MUL_W-1:0] a,
    input  logic signed [MUL_W-1:0] b,
    output logic signed [2*MUL_W-1:0] p
);

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign p = prod_reg;

endmodule

// File: src/point_on_segment_test_3d_core.sv
// top level of the 3-d point-on-segment test pipeline
`timescale 1ns / 1ps

// Takes one test point T and one segment A-B per beat and answers whether T
// lies near the segment, together with a code naming the rule that decided.
// A new beat can be taken every clock cycle unless m_tready is low with every
// stage full; each beat passes one register per stage, the last one being the
// output register m_tdata. All arithmetic is exact integer math on the raw
// Q16.16 values: squared lengths and the dot product come from 33x33
// multipliers, the angle test 65536*dot^2 >= cos_sq_limit*|T-A|^2*|B-A|^2
// is built from 34x34 partial products summed over the later stages, and
// no product wider than one multiplier is formed in a single cycle. Each
// stage holds its item while the next one is full, so bubbles close up and
// s_tready stays high while any stage is empty; s_tready follows m_tready
// combinationally through the stage valid chain. Configuration writes take
// effect at once and are meant for idle periods only. There is no startup
// sweep: the block is ready in the first cycle after reset.

module point_on_segment_test_3d_core
    import pos3d_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // dim_count[7:0], test_x, test_y, test_z, first_x, first_y, first_z,
    // second_x, second_y, second_z (32 bits each), low bits first
    input  logic [S_TDATA_W-1:0]  s_tdata,

    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // is_between[0], outcome[3:1], zero[7:4]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [NEAR_W-1:0] near_dist_sq_reg;
    logic [COS_W-1:0]  cos_sq_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_dist_sq_reg <= NEAR_RESET;
            cos_sq_limit_reg <= COS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_NEAR_DIST_SQ: near_dist_sq_reg <= cfg_wdata[NEAR_W-1:0];
                REG_COS_SQ_LIMIT: cos_sq_limit_reg <= cfg_wdata[COS_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or when the stage
    // after it loads, so a stall keeps every item and bubbles collapse
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];

    // ------------------------------------------------------------------
    // stage 0: difference vectors T-A, B-A, T-B (33 bits, exact)
    // ------------------------------------------------------------------
    logic        [7:0]  in_dim;
    logic signed [31:0] in_t [3];
    logic signed [31:0] in_a [3];
    logic signed [31:0] in_b [3];

    always_comb begin
        in_dim = s_tdata[7:0];
        for (int i = 0; i < 3; i++) begin
            in_t[i] = s_tdata[8 + 32*i +: 32];
            in_a[i] = s_tdata[104 + 32*i +: 32];
            in_b[i] = s_tdata[200 + 32*i +: 32];
        end
    end

    logic signed [32:0] dd0_reg [3];  // T - A
    logic signed [32:0] ds0_reg [3];  // B - A
    logic signed [32:0] db0_reg [3];  // T - B
    logic               dim0_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dim0_reg <= (in_dim == DIMS_ACCEPTED);
            for (int i = 0; i < 3; i++) begin
                dd0_reg[i] <= {in_t[i][31], in_t[i]} - {in_a[i][31], in_a[i]};
                ds0_reg[i] <= {in_b[i][31], in_b[i]} - {in_a[i][31], in_a[i]};
                db0_reg[i] <= {in_t[i][31], in_t[i]} - {in_b[i][31], in_b[i]};
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: squares and per-axis products of T-A with B-A, one multiplier each
    // ------------------------------------------------------------------
    logic signed [2*MUL_W-1:0] sqd_p [3];
    logic signed [2*MUL_W-1:0] sqs_p [3];
    logic signed [2*MUL_W-1:0] sqb_p [3];
    logic signed [2*MUL_W-1:0] xds_p [3];
    logic                      dim1_reg;

    for (genvar i = 0; i < 3; i++) begin : g_s1
        pos3d_mul u_sqd (
            .aclk (aclk), .en (en[1]),
            .a ({dd0_reg[i][32], dd0_reg[i]}), .b ({dd0_reg[i][32], dd0_reg[i]}),
            .p (sqd_p[i])
        );
        pos3d_mul u_sqs (
            .aclk (aclk), .en (en[1]),
            .a ({ds0_reg[i][32], ds0_reg[i]}), .b ({ds0_reg[i][32], ds0_reg[i]}),
            .p (sqs_p[i])
        );
        pos3d_mul u_sqb (
            .aclk (aclk), .en (en[1]),
            .a ({db0_reg[i][32], db0_reg[i]}), .b ({db0_reg[i][32], db0_reg[i]}),
            .p (sqb_p[i])
        );
        pos3d_mul u_xds (
            .aclk (aclk), .en (en[1]),
            .a ({dd0_reg[i][32], dd0_reg[i]}), .b ({ds0_reg[i][32], ds0_reg[i]}),
            .p (xds_p[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            dim1_reg <= dim0_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: squared lengths (each square < 2^64) and the dot product
    // ------------------------------------------------------------------
    logic        [65:0] ld2_reg;   // |T-A|^2
    logic        [65:0] ls2_reg;   // |B-A|^2
    logic        [65:0] lb2_reg;   // |T-B|^2
    logic signed [66:0] dot2_reg;
    logic               dim2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            dim2_reg <= dim1_reg;
            ld2_reg  <= {2'b0, sqd_p[0][63:0]} + {2'b0, sqd_p[1][63:0]}
                      + {2'b0, sqd_p[2][63:0]};
            ls2_reg  <= {2'b0, sqs_p[0][63:0]} + {2'b0, sqs_p[1][63:0]}
                      + {2'b0, sqs_p[2][63:0]};
            lb2_reg  <= {2'b0, sqb_p[0][63:0]} + {2'b0, sqb_p[1][63:0]}
                      + {2'b0, sqb_p[2][63:0]};
            dot2_reg <= 67'(xds_p[0] + xds_p[1] + xds_p[2]);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: coincidence rules, sign of the dot product, length order;
    // partial products of cos*|T-A|^2 and dot^2 start here
    // ------------------------------------------------------------------
    logic     coinc_ba;
    logic     coinc_ta;
    logic     coinc_tb;
    logic     dot_pos;
    verdict_t verdict3_next;

    always_comb begin
        coinc_ba = ls2_reg < {34'b0, near_dist_sq_reg};
        coinc_ta = ld2_reg < {34'b0, near_dist_sq_reg};
        coinc_tb = lb2_reg < {34'b0, near_dist_sq_reg};
        dot_pos  = !dot2_reg[66] && (dot2_reg != '0);

        verdict3_next.early   = 1'b1;
        verdict3_next.code    = OC_BAD_DIM;
        verdict3_next.between = 1'b0;
        verdict3_next.beyond  = ld2_reg > ls2_reg;
        if (!dim2_reg) begin
            verdict3_next.code = OC_BAD_DIM;
        end else if (coinc_ba) begin
            verdict3_next.code    = OC_ENDS_COINCIDE;
            verdict3_next.between = coinc_ta;
        end else if (coinc_ta || coinc_tb) begin
            verdict3_next.code    = OC_NEAR_END;
            verdict3_next.between = 1'b1;
        end else if (!dot_pos) begin
            verdict3_next.code = OC_ANGLE_WIDE;
        end else begin
            // left to the angle compare at the end of the pipe
            verdict3_next.early = 1'b0;
        end
    end

    logic signed [2*MUL_W-1:0] cl_lo_p;   // cos * ld[32:0]
    logic signed [2*MUL_W-1:0] cl_hi_p;   // cos * ld[65:33]
    logic signed [2*MUL_W-1:0] dll_p;     // dot_lo * dot_lo
    logic signed [2*MUL_W-1:0] dlh_p;     // dot_lo * dot_hi
    logic signed [2*MUL_W-1:0] dhh_p;     // dot_hi * dot_hi
    logic        [65:0]        ls3_reg;
    verdict_t                  verdict3_reg;

    pos3d_mul u_cl_lo (
        .aclk (aclk), .en (en[3]),
        .a ({17'b0, cos_sq_limit_reg}), .b ({1'b0, ld2_reg[32:0]}),
        .p (cl_lo_p)
    );
    pos3d_mul u_cl_hi (
        .aclk (aclk), .en (en[3]),
        .a ({17'b0, cos_sq_limit_reg}), .b ({1'b0, ld2_reg[65:33]}),
        .p (cl_hi_p)
    );
    pos3d_mul u_dll (
        .aclk (aclk), .en (en[3]),
        .a ({1'b0, dot2_reg[32:0]}), .b ({1'b0, dot2_reg[32:0]}),
        .p (dll_p)
    );
    pos3d_mul u_dlh (
        .aclk (aclk), .en (en[3]),
        .a ({1'b0, dot2_reg[32:0]}), .b ({1'b0, dot2_reg[65:33]}),
        .p (dlh_p)
    );
    pos3d_mul u_dhh (
        .aclk (aclk), .en (en[3]),
        .a ({1'b0, dot2_reg[65:33]}), .b ({1'b0, dot2_reg[65:33]}),
        .p (dhh_p)
    );

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            ls3_reg      <= ls2_reg;
            verdict3_reg <= verdict3_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: assemble cos*|T-A|^2 (< 2^84) and dot^2 (< 2^132)
    // ------------------------------------------------------------------
    logic [83:0]  cl4_reg;
    logic [131:0] dsq4_reg;
    logic [65:0]  ls4_reg;
    verdict_t     verdict4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            cl4_reg      <= {34'b0, cl_lo_p[49:0]} + {1'b0, cl_hi_p[49:0], 33'b0};
            dsq4_reg     <= {66'b0, dll_p[65:0]} + {32'b0, dlh_p[65:0], 34'b0}
                          + {dhh_p[65:0], 66'b0};
            ls4_reg      <= ls3_reg;
            verdict4_reg <= verdict3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: cos*|T-A|^2 * |B-A|^2 as 28-bit by 33-bit partial products
    // ------------------------------------------------------------------
    logic signed [2*MUL_W-1:0] rp_p [3][2];
    logic        [131:0]       dsq5_reg;
    verdict_t                  verdict5_reg;

    for (genvar i = 0; i < 3; i++) begin : g_rp_c
        for (genvar j = 0; j < 2; j++) begin : g_rp_l
            pos3d_mul u_rp (
                .aclk (aclk), .en (en[5]),
                .a ({6'b0, cl4_reg[28*i +: 28]}), .b ({1'b0, ls4_reg[33*j +: 33]}),
                .p (rp_p[i][j])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            dsq5_reg     <= dsq4_reg;
            verdict5_reg <= verdict4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: sum partial products per 33-bit chunk of |B-A|^2
    // ------------------------------------------------------------------
    logic [116:0] r6_reg [2];
    logic [131:0] dsq6_reg;
    verdict_t     verdict6_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            for (int j = 0; j < 2; j++) begin
                r6_reg[j] <= {56'b0, rp_p[0][j][60:0]}
                           + {28'b0, rp_p[1][j][60:0], 28'b0}
                           + {rp_p[2][j][60:0], 56'b0};
            end
            dsq6_reg     <= dsq5_reg;
            verdict6_reg <= verdict5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: full right-hand side (< 2^150)
    // ------------------------------------------------------------------
    logic [149:0] rhs7_reg;
    logic [131:0] dsq7_reg;
    verdict_t     verdict7_reg;

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            rhs7_reg     <= {33'b0, r6_reg[0]} + {r6_reg[1], 33'b0};
            dsq7_reg     <= dsq6_reg;
            verdict7_reg <= verdict6_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: angle compare (limit inclusive) and output register
    // ------------------------------------------------------------------
    logic     angle_ok;
    outcome_t out_code_next;
    logic     out_btw_next;
    outcome_t out_code_reg;
    logic     out_btw_reg;

    always_comb begin
        angle_ok      = {2'b0, dsq7_reg, 16'b0} >= rhs7_reg;
        out_code_next = verdict7_reg.code;
        out_btw_next  = verdict7_reg.between;
        if (!verdict7_reg.early) begin
            if (!angle_ok) begin
                out_code_next = OC_ANGLE_WIDE;
                out_btw_next  = 1'b0;
            end else if (verdict7_reg.beyond) begin
                out_code_next = OC_BEYOND;
                out_btw_next  = 1'b0;
            end else begin
                out_code_next = OC_BETWEEN;
                out_btw_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            out_code_reg <= out_code_next;
            out_btw_reg  <= out_btw_next;
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {4'b0, out_code_reg, out_btw_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a stage that cannot pass its item on keeps it
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((vld_reg & $past(vld_reg & ~en)) == $past(vld_reg & ~en)))
        else $error("pipeline stage dropped a held item");

    // input is refused only when every stage is full
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg))
        else $error("input refused with an empty stage");

    // rejecting outcomes never report the point as on the segment
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_code_reg == OC_BAD_DIM || out_code_reg == OC_ANGLE_WIDE
                      || out_code_reg == OC_BEYOND)) |-> !out_btw_reg)
        else $error("rejecting outcome with is_between set");

    // accepting outcomes always report the point as on the segment
    a_accept_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_code_reg == OC_NEAR_END || out_code_reg == OC_BETWEEN))
        |-> out_btw_reg)
        else $error("accepting outcome with is_between clear");

    // an item whose cheap rules passed always came through the angle test
    a_late_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NUM_STAGES-2] && en[NUM_STAGES-1] && !verdict7_reg.early)
        |=> (out_code_reg == OC_ANGLE_WIDE || out_code_reg == OC_BEYOND
             || out_code_reg == OC_BETWEEN))
        else $error("angle-tested item left with an early outcome");

endmodule
